@@ src/rir_pkg.sv @@
// Shared types, constants and the generator step for the ranged random block.
// No dependencies; every other file under src/ imports this package.
`default_nettype none

package rir_pkg;

	localparam logic [31:0] LCG_MUL     = 32'd1664525;
	localparam logic [31:0] LCG_ADD     = 32'd1013904223;
	localparam logic [31:0] DRAW_OFFSET = 32'h4000_0000;
	localparam logic [30:0] SCALE_TOP   = 31'h7FFF_FFFF;

	// One job word between front and back
	typedef struct packed {
		logic [31:0] lo;
		logic [30:0] div;
		logic        skip;
	} rir_job_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} rir_div_stat_t;

	function automatic logic [31:0] lcg_next(input logic [31:0] x);
		logic [31:0] p;
		p = x * LCG_MUL;
		return p + LCG_ADD;
	endfunction

endpackage

`default_nettype wire

@@ src/rir_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rir_pkg for the status struct.
`default_nettype none

module rir_div
	import rir_pkg::*;
#(
	parameter int NUM_W = 31,
	parameter int DEN_W = 31
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output rir_div_stat_t         stat,
	output logic      [NUM_W-1:0] quo
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			// shift one quotient bit in where the dividend bit leaves
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quo       = num_q;

endmodule

`default_nettype wire

@@ src/rir_front.sv @@
// Front end: accept a range word, classify it and compute the scale divisor.
// Depends on rir_pkg and rir_div.
`default_nettype none

module rir_front
	import rir_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic [31:0] range_low,
	input  wire logic [31:0] range_high,
	output logic             full,
	input  wire logic        q_full,
	output logic             q_push,
	output rir_job_t         job
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]    state_q;
	rir_job_t      job_q;
	logic          accept;
	logic          skip;
	logic [32:0]   span;
	logic          div_start;
	rir_div_stat_t div_stat;
	logic [30:0]   div_quo;

	assign accept    = push && (state_q == F_IDLE);
	assign skip      = $signed(range_high) <= $signed(range_low);
	assign span      = {range_high[31], range_high} - {range_low[31], range_low} + 33'd1;
	assign div_start = accept && !skip;

	rir_div #(
		.NUM_W(31),
		.DEN_W(33)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (SCALE_TOP),
		.den   (span),
		.stat  (div_stat),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= skip ? F_PUSH : F_DIV;
					end
				end
				F_DIV: begin
					if (div_stat.done) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.lo   <= range_low;
			job_q.skip <= skip;
			job_q.div  <= 31'd1;
		end else if (state_q == F_DIV && div_stat.done) begin
			// span beyond the scale top gives zero: use one instead
			job_q.div <= (div_quo == '0) ? 31'd1 : div_quo;
		end
	end

	assign full   = (state_q != F_IDLE);
	assign q_push = (state_q == F_PUSH) && !q_full;
	assign job    = job_q;

endmodule

`default_nettype wire

@@ src/rir_queue.sv @@
// Short flip-flop queue of job words between front and back.
// Depends on rir_pkg for the job word type.
`default_nettype none

module rir_queue
	import rir_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr,
	input  wire rir_job_t           wr_job,
	input  wire logic               rd,
	output rir_job_t                rd_job,
	output logic                    full,
	output logic                    empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	rir_job_t        mem_q [DEPTH];
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   rp_q;
	logic [LW-1:0]   cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = (cnt_q == LW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + LW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	assign rd_job = mem_q[rp_q];
	assign level  = cnt_q;

endmodule

`default_nettype wire

@@ src/rir_back.sv @@
// Back end: step the generator, scale the draw and hold the result word.
// Depends on rir_pkg and rir_div.
`default_nettype none

module rir_back
	import rir_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] seed,
	input  wire logic        q_empty,
	input  wire rir_job_t    q_job,
	output logic             q_pop,
	input  wire logic        out_pop,
	output logic             out_valid,
	output logic [31:0]      out_value,
	output logic [30:0]      out_raw
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_SEED = 3'd1;
	localparam logic [2:0] B_STEP = 3'd2;
	localparam logic [2:0] B_RAW  = 3'd3;
	localparam logic [2:0] B_DIV  = 3'd4;
	localparam logic [2:0] B_DONE = 3'd5;

	logic [2:0]    state_q;
	logic [31:0]   gen_q;
	logic [31:0]   lo_q;
	logic [30:0]   div_q;
	logic          skip_q;
	logic [30:0]   raw_q;
	logic          valid_q;
	logic [31:0]   value_q;
	logic [30:0]   oraw_q;
	logic [31:0]   half;
	logic [31:0]   raw_sum;
	logic [30:0]   raw_now;
	logic          div_start;
	rir_div_stat_t div_stat;
	logic [30:0]   div_quo;
	logic          load;
	logic [31:0]   addend;

	assign half      = {gen_q[31], gen_q[31:1]};
	assign raw_sum   = half + DRAW_OFFSET;
	assign raw_now   = raw_sum[30:0];
	assign div_start = (state_q == B_RAW);
	assign q_pop     = (state_q == B_IDLE) && !q_empty;
	assign load      = (state_q == B_DONE) && (!valid_q || out_pop);
	assign addend    = skip_q ? 32'd0 : {1'b0, div_quo};

	rir_div #(
		.NUM_W(31),
		.DEN_W(31)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (raw_now),
		.den   (div_q),
		.stat  (div_stat),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			gen_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						if (q_job.skip) begin
							state_q <= B_DONE;
						end else if (gen_q == '0) begin
							state_q <= B_SEED;
						end else begin
							state_q <= B_STEP;
						end
					end
				end
				B_SEED: begin
					gen_q   <= lcg_next(seed);
					state_q <= B_STEP;
				end
				B_STEP: begin
					gen_q   <= lcg_next(gen_q);
					state_q <= B_RAW;
				end
				B_RAW: state_q <= B_DIV;
				B_DIV: begin
					if (div_stat.done) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (load) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			lo_q   <= q_job.lo;
			div_q  <= q_job.div;
			skip_q <= q_job.skip;
			raw_q  <= '0;
		end else if (state_q == B_RAW) begin
			raw_q <= raw_now;
		end
		if (load) begin
			value_q <= lo_q + addend;
			oraw_q  <= raw_q;
		end
	end

	assign out_valid = valid_q;
	assign out_value = value_q;
	assign out_raw   = oraw_q;

endmodule

`default_nettype wire

@@ src/lcg_random_in_range.sv @@
// Top level of the ranged random generator: seed register, front, queue, back.
// Depends on rir_pkg, rir_front, rir_queue, rir_back.
//
// Usage
//   Request channel: drive range_low / range_high (signed, inclusive) and raise
//   push; the word is taken at an edge where push is high and full is low.
//   Result channel: while empty is low, random_value and raw_draw show the
//   oldest result; pop at an edge where empty is low takes it.
//   Seed: cfg_wr_en with cfg_wr_data writes the seed register at that edge.
//   Write it only while no request is in flight.
// Sequence
//   The front end takes a new request only after it has written the
//   previous job to the queue: accept, serial divisor divide, queue write;
//   an empty range skips the divide.
//   The back end pops the next job only after loading the current result:
//   optional seed step, generator step, serial scale divide, result load;
//   an empty range skips straight to the result load.
// Reset
//   Clear the seed register to zero and the generator to the unseeded state;
//   drop all queued and pending words.
// Stall
//   When the result is not popped, the back end holds its finished word, the
//   queue fills, and full then stays high; no word is lost.
`default_nettype none

module lcg_random_in_range
	import rir_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] range_low,
	input  wire logic [31:0] range_high,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      random_value,
	output logic [30:0]      raw_draw,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);

	logic [31:0]                      seed_q;
	logic                             q_full;
	logic                             q_empty;
	logic                             q_push;
	logic                             q_pop;
	rir_job_t                         push_job;
	rir_job_t                         pop_job;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;
	logic                             out_valid;
	logic                             out_pop;

	// Seed register: reset to zero, written on each enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	// Accept, classify and compute the scale divisor
	rir_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.range_low (range_low),
		.range_high(range_high),
		.full      (full),
		.q_full    (q_full),
		.q_push    (q_push),
		.job       (push_job)
	);

	// Decouple front from back
	rir_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_push),
		.wr_job(push_job),
		.rd    (q_pop),
		.rd_job(pop_job),
		.full  (q_full),
		.empty (q_empty),
		.level (q_level)
	);

	// Advance the generator, scale and hold the result word
	rir_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.seed     (seed_q),
		.q_empty  (q_empty),
		.q_job    (pop_job),
		.q_pop    (q_pop),
		.out_pop  (out_pop),
		.out_valid(out_valid),
		.out_value(random_value),
		.out_raw  (raw_draw)
	);

	assign empty   = !out_valid;
	assign out_pop = pop && out_valid;

	// Front goes busy right after taking a word
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("front did not go busy after accepting a word");

	// Queue level never exceeds its depth
	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
		else $error("queue level above depth");

	// Drawing jobs always carry a nonzero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !push_job.skip |-> push_job.div != '0)
		else $error("zero divisor pushed to queue");

endmodule

`default_nettype wire

@@ bench/tb_lcg_random_in_range.sv @@
// Self-checking bench for lcg_random_in_range: range draw predictor, scoreboard, drivers.
// Needs only the RTL under src/ (rir_pkg and the lcg_random_in_range hierarchy).
`timescale 1ns / 1ps

typedef struct {
	logic [31:0] value;
	logic [30:0] draw;
} draw_result_t;

// Tracks seed and generator state, turns each accepted request into the
// expected result word, and compares result words in order.
class range_draw_scoreboard;
	localparam bit [31:0] GEN_MUL   = 32'd1664525;
	localparam bit [31:0] GEN_ADD   = 32'd1013904223;
	localparam bit [31:0] DRAW_BIAS = 32'h4000_0000;
	localparam longint    SCALE_MAX = 64'd2147483647;

	bit [31:0]    seed_reg;
	bit [31:0]    gen_state;
	draw_result_t expected_q[$];
	int unsigned  mismatches;

	function new();
		seed_reg   = '0;
		gen_state  = '0;
		mismatches = 0;
	endfunction

	function void set_seed(bit [31:0] v);
		seed_reg = v;
	endfunction

	function bit [31:0] gen_step(bit [31:0] x);
		return x * GEN_MUL + GEN_ADD;
	endfunction

	function void note_request(logic [31:0] lo, logic [31:0] hi);
		longint       span;
		longint       divisor;
		longint       quot;
		bit [31:0]    half;
		draw_result_t r;
		if ($signed(hi) <= $signed(lo)) begin
			// empty range: echo lower bound, generator holds
			r.value = lo;
			r.draw  = '0;
		end else begin
			span    = longint'($signed(hi)) - longint'($signed(lo)) + 1;
			divisor = SCALE_MAX / span;
			if (divisor == 0)
				divisor = 1;
			if (gen_state == 0)
				gen_state = gen_step(seed_reg);
			gen_state = gen_step(gen_state);
			half      = {gen_state[31], gen_state[31:1]};
			r.draw    = 31'(half + DRAW_BIAS);
			quot      = longint'(r.draw) / divisor;
			r.value   = lo + quot[31:0];
		end
		expected_q.push_back(r);
	endfunction

	function void check_result(logic [31:0] value, logic [30:0] draw);
		draw_result_t r;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result word: random_value %h raw_draw %h",
				$time, value, draw);
			mismatches++;
			return;
		end
		r = expected_q.pop_front();
		if (value !== r.value) begin
			$display("%0t: random_value mismatch: expected %h actual %h",
				$time, r.value, value);
			mismatches++;
		end
		if (draw !== r.draw) begin
			$display("%0t: raw_draw mismatch: expected %h actual %h",
				$time, r.draw, draw);
			mismatches++;
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb_lcg_random_in_range;

	// Cycles with no word moving on either side before we give up. Worst
	// honest gap is one request latency plus random receiver stalls.
	localparam int STALL_LIMIT   = 4000;
	// Cycles to keep watching after the last expected word, to catch extras.
	localparam int DRAIN_CYCLES  = 150;
	localparam int RANDOM_WORDS  = 150;

	// Corner requests {range_low, range_high}: empty ranges (equal, reversed,
	// at the extremes), spans of two, spans at and around 2^30 and 2^31, the
	// full 2^32 span where the divisor clamps to one, and a sum that wraps.
	localparam int N_CORNER = 19;
	localparam logic [63:0] CORNER_PAIRS [N_CORNER] = '{
		{32'h0000_0000, 32'h0000_0000},
		{32'h7FFF_FFFF, 32'h8000_0000},
		{32'h8000_0000, 32'h7FFF_FFFF},
		{32'h0000_0000, 32'h0000_0001},
		{32'hFFFF_FFFF, 32'h0000_0000},
		{32'h8000_0000, 32'h8000_0001},
		{32'h7FFF_FFFE, 32'h7FFF_FFFF},
		{32'h0000_0000, 32'h7FFF_FFFE},
		{32'h0000_0000, 32'h7FFF_FFFF},
		{32'hFFFF_FFFF, 32'h7FFF_FFFF},
		{32'h0000_0001, 32'h7FFF_FFFF},
		{32'h0000_0000, 32'h3FFF_FFFF},
		{32'h0000_0000, 32'h3FFF_FFFE},
		{32'h0000_0064, 32'h0000_00C7},
		{32'h8000_0000, 32'hFFFF_FFFF},
		{32'h7FFF_FFFF, 32'h7FFF_FFFF},
		{32'h8000_0000, 32'h8000_0000},
		{32'h0000_0005, 32'hFFFF_FFFB},
		{32'hFFFF_FFFF, 32'hFFFF_FFFF}
	};

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [31:0] range_low;
	logic [31:0] range_high;
	logic        empty;
	logic        pop;
	logic [31:0] random_value;
	logic [30:0] raw_draw;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	// Idle percentages for each side; the main sequence changes them per phase.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned quiet_cycles;

	range_draw_scoreboard sb;

	lcg_random_in_range u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.range_low    (range_low),
		.range_high   (range_high),
		.empty        (empty),
		.pop          (pop),
		.random_value (random_value),
		.raw_draw     (raw_draw),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: decide pop on each falling edge. pop gets exactly one
	// assignment per step, so a run of pops never glitches low.
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Sample at the rising edge: check popped words, and count cycles in
	// which no word moved on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result(random_value, raw_draw);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("lcg_random_in_range test failed");
				$finish;
			end
		end
	end

	// Offer one request word; called and returns at a falling edge. push is
	// left high on return so back-to-back words keep it high; the next call
	// or the drain step drops it.
	task automatic send_word(input logic [31:0] lo, input logic [31:0] hi);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push       <= 1'b1;
		range_low  <= lo;
		range_high <= hi;
		do
			@(posedge clk);
		while (full);
		sb.note_request(lo, hi);
		@(negedge clk);
	endtask

	// Drop push and hold until every expected result word has been popped.
	// Every request yields exactly one word, so the block is idle after this.
	task automatic wait_drained();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Seed write: one cycle of cfg_wr_en, only while the block is idle.
	task automatic write_seed(input logic [31:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		sb.set_seed(v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random requests: random lower bound, span width drawn from 0..32 bits
	// so divisors of every size show up, mostly ascending ranges clamped at
	// the signed top, and about one in five reversed or equal (empty).
	task automatic run_random(input int unsigned count);
		logic [31:0] lo;
		longint      lo_s;
		longint      hi_s;
		longint      width;
		int unsigned k;
		for (int unsigned i = 0; i < count; i++) begin
			lo    = $urandom;
			lo_s  = longint'($signed(lo));
			k     = $urandom_range(0, 32);
			width = longint'({32'd0, $urandom}) & ((longint'(1) << k) - 1);
			if ($urandom_range(0, 9) < 2) begin
				hi_s = lo_s - width;
				if (hi_s < -64'sd2147483648)
					hi_s = -64'sd2147483648;
			end else begin
				hi_s = lo_s + width;
				if (hi_s > 64'sd2147483647)
					hi_s = 64'sd2147483647;
			end
			send_word(lo, hi_s[31:0]);
		end
	endtask

	initial begin
		logic [31:0] mul_inv;
		logic [31:0] zero_seed;

		arst_n        = 1'b0;
		push          = 1'b0;
		range_low     = '0;
		range_high    = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		quiet_cycles  = 0;
		send_idle_pct = 34;
		recv_idle_pct = 56;
		sb            = new();

		// Find the seed whose first draw lands the generator on zero: walk
		// the step backwards twice from zero. The multiplier inverse mod 2^32
		// comes from Newton iteration (each pass doubles the correct bits).
		mul_inv = 32'd1664525;
		repeat (5)
			mul_inv = mul_inv * (32'd2 - 32'd1664525 * mul_inv);
		zero_seed = (32'd0 - 32'd1013904223) * mul_inv;
		zero_seed = (zero_seed - 32'd1013904223) * mul_inv;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Corners under the zero-returning seed: every draw leaves the state
		// at zero, so each one reseeds, and the state stays unseeded after.
		write_seed(zero_seed);
		for (int i = 0; i < N_CORNER; i++)
			send_word(CORNER_PAIRS[i][63:32], CORNER_PAIRS[i][31:0]);
		wait_drained();

		// State is zero here, so this seed is the one the generator takes.
		write_seed(32'h0000_0000);
		run_random(RANDOM_WORDS);
		wait_drained();

		// Swap the idle pattern; the all-ones seed is written but the state
		// is already nonzero, so it must not disturb the sequence.
		send_idle_pct = 56;
		recv_idle_pct = 34;
		write_seed(32'hFFFF_FFFF);
		run_random(RANDOM_WORDS);
		wait_drained();

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_seed($urandom);
		run_random(RANDOM_WORDS);
		wait_drained();

		// Keep watching for stray result words before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("lcg_random_in_range test passed");
		end else begin
			if (sb.pending() != 0)
				$display("%0t: %0d expected result words never arrived",
					$time, sb.pending());
			$display("lcg_random_in_range test failed");
		end
		$finish;
	end

endmodule
